// ===== rtl/core/ism_pkg.sv =====
`timescale 1ns / 1ps
package ism_pkg;
    typedef struct packed {
        logic signed [31:0] interval_start;
        logic signed [31:0] interval_end;
        logic               last_interval;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] merged_start;
        logic signed [31:0] merged_end;
        logic               last_merged;
        logic               overflow;
    } t_out_item;
endpackage

// ===== rtl/core/ism_front.sv =====
`timescale 1ns / 1ps
// Front part: accepts intervals and classifies each as stored or dropped,
// keeping the fill count and the overflow mark of the current set.
module ism_front #(
    parameter int MAX_INTERVALS = 64,
    parameter int POINT_WIDTH   = 32,
    localparam int CW           = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  ism_pkg::t_in_item        i_item,
    output logic                     o_q_valid,
    input  logic                     i_q_ready,
    output logic [POINT_WIDTH-1:0]   o_q_start,
    output logic [POINT_WIDTH-1:0]   o_q_end,
    output logic                     o_q_store,
    output logic                     o_q_last,
    output logic                     o_q_ovf
);
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_qv;
    logic [POINT_WIDTH-1:0] r_qs, r_qe;
    logic          r_qst, r_ql, r_qo;
    logic          w_full, w_acc;

    assign o_ready = !r_qv || i_q_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_full  = (r_count == CW'(MAX_INTERVALS));

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (w_acc) begin
            if (i_item.last_interval) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_qv    <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
            if (w_acc) begin
                r_qv <= 1'b1;
            end else if (i_q_ready) begin
                r_qv <= 1'b0;
            end
        end
        if (w_acc) begin
            r_qs  <= i_item.interval_start[POINT_WIDTH-1:0];
            r_qe  <= i_item.interval_end[POINT_WIDTH-1:0];
            r_qst <= !w_full;
            r_ql  <= i_item.last_interval;
            r_qo  <= r_ovf || w_full;
        end
    end

    assign o_q_valid = r_qv;
    assign o_q_start = r_qs;
    assign o_q_end   = r_qe;
    assign o_q_store = r_qst;
    assign o_q_last  = r_ql;
    assign o_q_ovf   = r_qo;
endmodule

// ===== rtl/core/ism_back.sv =====
`timescale 1ns / 1ps
// Back part: a sorted chain of cells. Each stored interval is inserted at its
// sorted place; on the last transfer the chain shifts out from the head while
// runs are merged, one cell per cycle unless a closing run waits on the output.
module ism_back #(
    parameter int MAX_INTERVALS = 64,
    parameter int POINT_WIDTH   = 32,
    localparam int CW           = $clog2(MAX_INTERVALS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_valid,
    output logic                     o_q_ready,
    input  logic [POINT_WIDTH-1:0]   i_q_start,
    input  logic [POINT_WIDTH-1:0]   i_q_end,
    input  logic                     i_q_store,
    input  logic                     i_q_last,
    input  logic                     i_q_ovf,
    output logic                     o_valid,
    input  logic                     i_ready,
    output ism_pkg::t_out_item       o_item
);
    typedef enum logic [1:0] {S_FILL, S_SEED, S_DRAIN, S_FLUSH} t_state;
    localparam int N = MAX_INTERVALS;

    t_state r_state;
    logic signed [POINT_WIDTH-1:0] r_cs [N];
    logic signed [POINT_WIDTH-1:0] r_ce [N];
    logic [CW-1:0] r_n;
    logic          r_ovf;
    logic signed [POINT_WIDTH-1:0] r_rs, r_re;
    logic          r_ov;
    ism_pkg::t_out_item r_out;
    logic          w_gt [N];
    logic          w_ins, w_shift, w_out_free, w_join, w_emit;
    logic signed [POINT_WIDTH-1:0] w_ns, w_ne;

    assign w_ns = signed'(i_q_start);
    assign w_ne = signed'(i_q_end);
    assign o_q_ready = (r_state == S_FILL);
    assign w_ins = i_q_valid && o_q_ready && i_q_store;
    assign w_out_free = !r_ov || i_ready;
    assign w_join = (r_cs[0] <= r_re);
    // One head cell leaves per drain step; a new run emits only when free.
    assign w_shift = (r_state == S_SEED) ||
                     ((r_state == S_DRAIN) && r_n != '0 && (w_join || w_out_free));
    // A result is loaded when a run closes during the drain or at the flush.
    assign w_emit = ((r_state == S_DRAIN) && w_shift && !w_join) ||
                    ((r_state == S_FLUSH) && w_out_free);

    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_gt[i] = (CW'(i) < r_n) && (r_cs[i] > w_ns);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (w_ins) begin
                if (i > 0 && w_gt[i-1]) begin
                    r_cs[i] <= r_cs[i-1];
                    r_ce[i] <= r_ce[i-1];
                end else if (w_gt[i] || CW'(i) == r_n) begin
                    r_cs[i] <= w_ns;
                    r_ce[i] <= w_ne;
                end
            end else if (w_shift && i < N - 1) begin
                r_cs[i] <= r_cs[i+1];
                r_ce[i] <= r_ce[i+1];
            end
        end
        if (w_shift && r_state == S_SEED) begin
            r_rs <= r_cs[0];
            r_re <= r_ce[0];
        end else if (w_shift) begin
            if (w_join) begin
                if (r_ce[0] > r_re) r_re <= r_ce[0];
            end else begin
                r_rs <= r_cs[0];
                r_re <= r_ce[0];
            end
        end
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_n     <= '0;
            r_ovf   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    if (i_q_valid) begin
                        if (w_ins) r_n <= r_n + 1'b1;
                        r_ovf <= i_q_ovf;
                        if (i_q_last) r_state <= S_SEED;
                    end
                end
                S_SEED: begin
                    r_n     <= r_n - 1'b1;
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_n == '0) begin
                        r_state <= S_FLUSH;
                    end else if (w_shift) begin
                        r_n <= r_n - 1'b1;
                        if (!w_join) begin
                            r_out <= '{merged_start: 32'(r_rs), merged_end: 32'(r_re),
                                       last_merged: 1'b0, overflow: r_ovf};
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out <= '{merged_start: 32'(r_rs), merged_end: 32'(r_re),
                                   last_merged: 1'b1, overflow: r_ovf};
                        r_n   <= '0;
                        r_ovf <= 1'b0;
                        r_state <= S_FILL;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(N)) else $error("cell count above capacity");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FILL) |-> !o_q_ready) else $error("queue taken while draining");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))
        else $error("result changed while stalled");
`endif
endmodule

// ===== rtl/core/interval_sort_merge.sv =====
`timescale 1ns / 1ps
// interval_sort_merge takes one closed interval per transfer and inserts it
// into a chain of start-sorted cells, so a set streams in at one interval per
// cycle while the chain is filling. A transfer flagged last_interval starts
// the drain: overlapping or touching intervals are merged as the chain shifts
// out one cell per cycle, unless a closing run waits on a stalled output, and
// each disjoint run leaves through a registered output; the last result
// carries last_merged. While a set drains, no new interval is taken past the
// one-entry queue between the front and the chain.
// Intervals beyond MAX_INTERVALS are dropped and overflow is set on every
// result of that set. Points are read in their low POINT_WIDTH bits, signed.
module interval_sort_merge #(
    parameter int MAX_INTERVALS = 64,
    parameter int POINT_WIDTH   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ism_pkg::t_in_item     i_item,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ism_pkg::t_out_item    o_item
);
    logic                   w_qv, w_qr, w_qst, w_ql, w_qo;
    logic [POINT_WIDTH-1:0] w_qs, w_qe;
    ism_pkg::t_out_item     w_raw;

    ism_front #(.MAX_INTERVALS(MAX_INTERVALS), .POINT_WIDTH(POINT_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_item(i_item), .o_q_valid(w_qv), .i_q_ready(w_qr), .o_q_start(w_qs),
        .o_q_end(w_qe), .o_q_store(w_qst), .o_q_last(w_ql), .o_q_ovf(w_qo));

    ism_back #(.MAX_INTERVALS(MAX_INTERVALS), .POINT_WIDTH(POINT_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .o_q_ready(w_qr),
        .i_q_start(w_qs), .i_q_end(w_qe), .i_q_store(w_qst), .i_q_last(w_ql),
        .i_q_ovf(w_qo), .o_valid(o_valid), .i_ready(i_ready), .o_item(w_raw));

    // Points are carried at POINT_WIDTH and sign extended on the way out.
    assign o_item.merged_start = 32'(signed'(w_raw.merged_start[POINT_WIDTH-1:0]));
    assign o_item.merged_end   = 32'(signed'(w_raw.merged_end[POINT_WIDTH-1:0]));
    assign o_item.last_merged  = w_raw.last_merged;
    assign o_item.overflow     = w_raw.overflow;
endmodule

// ===== tb/tb_interval_sort_merge.sv =====
`timescale 1ns / 1ps
module tb_interval_sort_merge;
    localparam int CAPACITY = 64;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    ism_pkg::t_in_item  in_item;
    logic               out_valid;
    logic               out_ready;
    ism_pkg::t_out_item out_item;

    interval_sort_merge i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    // Intervals waiting to be driven, and merged runs the block must produce.
    ism_pkg::t_in_item  pending_intervals[$];
    ism_pkg::t_out_item expected_runs[$];

    // Predictor state: the intervals of the set being collected.
    logic signed [31:0] set_starts[$];
    logic signed [31:0] set_ends[$];
    bit                 set_overflow;

    int mismatches;
    bit stimulus_done;
    int cycle_count;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Accept one interval into the predicted set; on the last one, order by start
    // (stable) and merge runs whose start does not exceed the current run end.
    task automatic collect_interval(input ism_pkg::t_in_item it);
        logic signed [31:0] s_sorted[$];
        logic signed [31:0] e_sorted[$];
        logic signed [31:0] run_s;
        logic signed [31:0] run_e;
        ism_pkg::t_out_item run;
        int                 j;
        if (set_starts.size() < CAPACITY) begin
            set_starts.insert(set_starts.size(), it.interval_start);
            set_ends.insert(set_ends.size(), it.interval_end);
        end else begin
            set_overflow = 1'b1;
        end
        if (!it.last_interval) return;
        // Insertion sort keeps equal starts in arrival order.
        for (int i = 0; i < set_starts.size(); i++) begin
            j = s_sorted.size();
            while (j > 0 && s_sorted[j-1] > set_starts[i]) j--;
            s_sorted.insert(j, set_starts[i]);
            e_sorted.insert(j, set_ends[i]);
        end
        run_s = s_sorted[0];
        run_e = e_sorted[0];
        for (int i = 1; i < s_sorted.size(); i++) begin
            if (s_sorted[i] <= run_e) begin
                if (e_sorted[i] > run_e) run_e = e_sorted[i];
            end else begin
                run = '{run_s, run_e, 1'b0, set_overflow};
                expected_runs.insert(expected_runs.size(), run);
                run_s = s_sorted[i];
                run_e = e_sorted[i];
            end
        end
        run = '{run_s, run_e, 1'b1, set_overflow};
        expected_runs.insert(expected_runs.size(), run);
        set_starts.delete();
        set_ends.delete();
        set_overflow = 1'b0;
    endtask

    function automatic ism_pkg::t_in_item make_interval(input logic signed [31:0] s,
                                                        input logic signed [31:0] e,
                                                        input bit last);
        ism_pkg::t_in_item it;
        it.interval_start = s;
        it.interval_end   = e;
        it.last_interval  = last;
        return it;
    endfunction

    // Random endpoint: mostly clustered so runs overlap, sometimes full range.
    function automatic logic signed [31:0] random_point(input int spread);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $signed($urandom_range(0, spread)) - spread / 2;
    endfunction

    // Idling is turned off for a stretch in the middle of the run.
    function automatic bit want_idle();
        if (cycle_count > 300 && cycle_count < 700) return 1'b0;
        return $urandom_range(0, 99) < 16;
    endfunction

    // Driver: holds valid and payload until the transfer completes.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (pending_intervals.size() > 0 && !want_idle()) begin
                in_item  <= pending_intervals.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Input monitor feeds the predictor on each accepted transfer.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) collect_interval(in_item);
    end

    // Output side: random back-pressure and field-by-field comparison.
    always @(posedge clk) begin
        ism_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= !want_idle();
            if (out_valid && out_ready) begin
                if (expected_runs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d..%0d last=%0b ovf=%0b",
                                 out_item.merged_start, out_item.merged_end,
                                 out_item.last_merged, out_item.overflow);
                end else begin
                    want = expected_runs.pop_front();
                    if (out_item.merged_start !== want.merged_start ||
                        out_item.merged_end !== want.merged_end ||
                        out_item.last_merged !== want.last_merged ||
                        out_item.overflow !== want.overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d..%0d l=%0b o=%0b, got %0d..%0d l=%0b o=%0b",
                                     want.merged_start, want.merged_end,
                                     want.last_merged, want.overflow,
                                     out_item.merged_start, out_item.merged_end,
                                     out_item.last_merged, out_item.overflow);
                    end
                end
            end
        end
    end

    initial begin
        int total;
        int n;
        int spread;
        mismatches   = 0;
        cycle_count  = 0;
        set_overflow = 1'b0;
        stimulus_done = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        rst_n     = 1'b0;
        // Directed sets: single interval, extremes, touching, nested,
        // start above end, equal starts.
        pending_intervals.insert(pending_intervals.size(),
                                 make_interval(32'sh7fffffff, 32'sh80000000, 1'b1));
        pending_intervals.insert(pending_intervals.size(),
                                 make_interval(32'sh80000000, 32'sh80000000, 1'b0));
        pending_intervals.insert(pending_intervals.size(),
                                 make_interval(32'sh7fffffff, 32'sh7fffffff, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(-5, 5, 1'b1));
        pending_intervals.insert(pending_intervals.size(), make_interval(10, 20, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(1, 10, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(2, 3, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(21, 30, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(21, 25, 1'b1));
        pending_intervals.insert(pending_intervals.size(), make_interval(40, 30, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(35, 50, 1'b0));
        pending_intervals.insert(pending_intervals.size(), make_interval(-1, -1, 1'b1));
        // A set that overflows the store; the last interval itself is dropped.
        for (int i = 0; i < 70; i++)
            pending_intervals.insert(pending_intervals.size(),
                                     make_interval(i * 3, i * 3 + 1, i == 69));
        // Exactly full store.
        for (int i = 0; i < 64; i++)
            pending_intervals.insert(pending_intervals.size(),
                                     make_interval(-i * 2, -i * 2, i == 63));
        total = 0;
        while (total < 250) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 66)
                                              : $urandom_range(1, 10);
            spread = ($urandom_range(0, 1) == 1) ? 40 : 100000;
            for (int i = 0; i < n; i++)
                pending_intervals.insert(pending_intervals.size(),
                                         make_interval(random_point(spread),
                                                       random_point(spread),
                                                       i == n - 1));
            total += n;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_intervals.size() == 0);
        @(posedge clk);
        while (in_valid) @(posedge clk);
        stimulus_done = 1'b1;
    end

    initial begin
        wait (stimulus_done);
        while (expected_runs.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_runs.size() == 0) begin
            $display("tb_interval_sort_merge OK");
        end else begin
            $display("tb_interval_sort_merge NOT OK");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("tb_interval_sort_merge NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ism_pkg.sv
rtl/core/ism_front.sv
rtl/core/ism_back.sv
rtl/core/interval_sort_merge.sv
tb/tb_interval_sort_merge.sv
